// ===== rtl/araf_pkg.sv =====
// Shared types and constants for the anchor range average filter.
// Depends on nothing; imported by the top level.
package araf_pkg;

	// Field and accumulator widths
	localparam int unsigned MM_W   = 18;
	localparam int unsigned SUM_W  = 26;
	localparam int unsigned CNT_W  = 8;
	localparam int unsigned IN_W   = 24;
	localparam int unsigned OUT_W  = 24;

	// Unit conversion and limits
	localparam int unsigned MM_PER_M  = 1000;
	localparam int unsigned MM_PER_CM = 10;
	localparam logic [CNT_W-1:0] COUNT_MAX     = 8'd255;
	localparam logic [CNT_W-1:0] REFRESH_RESET = 8'd10;

	// One quotient bit per divider step
	localparam int unsigned DIV_STEPS = SUM_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_CHECK,
		ST_LOAD,
		ST_DIV_MEAN,
		ST_PUSH,
		ST_SUM_RD,
		ST_SUM_ADD,
		ST_DIV_AVG,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/anchor_range_average_filter.sv =====
// Anchor range average filter: per-anchor block average then moving average.
// Depends on araf_pkg (state type, widths and constants).
//
// Each accepted report adds meters*1000 + centimeters*10 mm to its anchor's
// accumulator. A report that triggers no refresh round keeps s_axis_tready low
// after its transfer through the accumulate and threshold check states; reports
// for an anchor index >= ANCHORS are dropped with no wait. When any anchor's
// count has reached the threshold, a round emits one result per anchor.
// All division runs through one restoring divider that yields one quotient bit
// per cycle, so an anchor with reports passes through load, mean division,
// window push, a read and an add per window slot, average division and result,
// an anchor without reports through load and result, each plus any stall on
// m_axis_tready. No item is accepted during a round.
module anchor_range_average_filter #(
	parameter int unsigned ANCHORS = 4,
	parameter int unsigned WINDOW  = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// tdata: anchor_id[3:0], range_meters[11:4], range_centimeters[19:12]
	input  logic [araf_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// tdata: out_anchor[3:0], filtered_mm[21:4]
	output logic [araf_pkg::OUT_W-1:0] m_axis_tdata,
	// tuser: had_reports[0]
	output logic                       m_axis_tuser,
	output logic                       m_axis_tlast,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic                       cfg_wr_en,
	input  logic [araf_pkg::CNT_W-1:0] cfg_wr_data
);
	import araf_pkg::*;

	localparam int unsigned SLOTS = ANCHORS * WINDOW;
	localparam int unsigned AIW   = (ANCHORS > 1) ? $clog2(ANCHORS) : 1;
	localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned SW    = $clog2(DIV_STEPS);

	state_t state_q, state_d;

	logic [CNT_W-1:0] refresh_q;
	logic [AIW-1:0]   anc_q;
	logic [MM_W-1:0]  mm_q;
	logic [SUM_W-1:0] sum_q [ANCHORS];
	logic [CNT_W-1:0] cnt_q [ANCHORS];
	logic [PW-1:0]    ptr_q [ANCHORS];
	logic [AIW-1:0]   idx_q;
	logic [AW-1:0]    base_q;
	logic [PW-1:0]    k_q;
	logic [SUM_W-1:0] total_q;
	logic             had_q;

	// Shared divider registers
	logic [SUM_W-1:0] dvd_q;
	logic [CNT_W-1:0] dsr_q;
	logic [CNT_W-1:0] rem_q;
	logic [SW-1:0]    step_q;

	// Window memory and its per-slot valid bits
	logic [MM_W-1:0]  win_mem [SLOTS];
	logic [SLOTS-1:0] win_vld_q;
	logic [MM_W-1:0]  win_rd_q;
	logic             win_rd_vld_q;

	logic             in_xfer;
	logic             out_xfer;
	logic             in_range;
	logic [MM_W-1:0]  in_mm;
	logic [SUM_W:0]   acc_sum;
	logic             fire;
	logic [CNT_W:0]   rem_sh;
	logic             q_bit;
	logic [CNT_W-1:0] rem_n;
	logic [SUM_W-1:0] dvd_n;
	logic             div_last;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;
	logic [SUM_W-1:0] slot_val;
	logic [SUM_W-1:0] total_n;
	logic             push;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign in_range = {1'b0, s_axis_tdata[3:0]} < 5'(ANCHORS);
	assign in_mm    = MM_W'(s_axis_tdata[11:4]) * MM_W'(MM_PER_M)
	                + MM_W'(s_axis_tdata[19:12]) * MM_W'(MM_PER_CM);
	assign acc_sum  = {1'b0, sum_q[anc_q]} + (SUM_W+1)'(mm_q);

	// Any anchor at or above the threshold starts a round
	always_comb begin
		fire = 1'b0;
		for (int i = 0; i < ANCHORS; i++) begin
			if (cnt_q[i] >= refresh_q) begin
				fire = 1'b1;
			end
		end
	end

	// Restoring divider step
	assign rem_sh   = {rem_q, dvd_q[SUM_W-1]};
	assign q_bit    = rem_sh >= {1'b0, dsr_q};
	assign rem_n    = q_bit ? CNT_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[CNT_W-1:0];
	assign dvd_n    = {dvd_q[SUM_W-2:0], q_bit};
	assign div_last = step_q == SW'(DIV_STEPS - 1);

	assign wr_addr  = base_q + AW'(ptr_q[idx_q]);
	assign rd_addr  = base_q + AW'(k_q);
	assign slot_val = win_rd_vld_q ? SUM_W'(win_rd_q) : '0;
	assign total_n  = total_q + slot_val;
	assign push     = (state_q == ST_PUSH) && (dvd_q != '0);

	// Next state and handshake outputs
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (in_xfer && in_range) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: state_d = ST_CHECK;
			ST_CHECK: state_d = fire ? ST_LOAD : ST_IDLE;
			ST_LOAD: begin
				state_d = (cnt_q[idx_q] == '0) ? ST_OUT : ST_DIV_MEAN;
			end
			ST_DIV_MEAN: begin
				if (div_last) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH:    state_d = ST_SUM_RD;
			ST_SUM_RD:  state_d = ST_SUM_ADD;
			ST_SUM_ADD: begin
				state_d = (k_q == PW'(WINDOW - 1)) ? ST_DIV_AVG : ST_SUM_RD;
			end
			ST_DIV_AVG: begin
				if (div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					state_d = (idx_q == AIW'(ANCHORS - 1)) ? ST_IDLE : ST_LOAD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q <= REFRESH_RESET;
		end else if (cfg_wr_en) begin
			refresh_q <= cfg_wr_data;
		end
	end

	// Capture the report and its distance in mm
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			anc_q <= s_axis_tdata[AIW-1:0];
			mm_q  <= in_mm;
		end
	end

	// Accumulate reports; clear after the final result of a round
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ANCHORS; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else if (state_q == ST_ACCUM) begin
			sum_q[anc_q] <= acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
			if (cnt_q[anc_q] != COUNT_MAX) begin
				cnt_q[anc_q] <= cnt_q[anc_q] + 1'b1;
			end
		end else if (out_xfer && idx_q == AIW'(ANCHORS - 1)) begin
			for (int i = 0; i < ANCHORS; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end
	end

	// Advance the window write pointer on a push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ANCHORS; i++) begin
				ptr_q[i] <= '0;
			end
		end else if (push) begin
			ptr_q[idx_q] <= (ptr_q[idx_q] == PW'(WINDOW - 1)) ? '0 : ptr_q[idx_q] + 1'b1;
		end
	end

	// Round sequencing: anchor index, window base, slot counter, running total
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CHECK: begin
				idx_q  <= '0;
				base_q <= '0;
			end
			ST_PUSH: begin
				k_q     <= '0;
				total_q <= '0;
			end
			ST_SUM_ADD: begin
				k_q     <= k_q + 1'b1;
				total_q <= total_n;
			end
			ST_OUT: begin
				if (m_axis_tready) begin
					idx_q  <= idx_q + 1'b1;
					base_q <= base_q + AW'(WINDOW);
				end
			end
			default: begin
			end
		endcase
	end

	// Shared divider: load, step, hold the quotient for output
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				had_q  <= cnt_q[idx_q] != '0;
				dvd_q  <= (cnt_q[idx_q] == '0) ? '0 : sum_q[idx_q];
				dsr_q  <= cnt_q[idx_q];
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_SUM_ADD: begin
				dvd_q  <= total_n;
				dsr_q  <= CNT_W'(WINDOW);
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_DIV_MEAN, ST_DIV_AVG: begin
				dvd_q  <= dvd_n;
				rem_q  <= rem_n;
				step_q <= step_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Window memory write and registered read
	always_ff @(posedge clk) begin
		if (push) begin
			win_mem[wr_addr] <= dvd_q[MM_W-1:0];
		end
		win_rd_q <= win_mem[rd_addr];
	end

	// Slot valid bits: an unwritten slot reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_vld_q    <= '0;
			win_rd_vld_q <= 1'b0;
		end else begin
			if (push) begin
				win_vld_q[wr_addr] <= 1'b1;
			end
			win_rd_vld_q <= win_vld_q[rd_addr];
		end
	end

	// Result fields
	assign m_axis_tdata = {2'b00, dvd_q[MM_W-1:0], 4'(idx_q)};
	assign m_axis_tuser = had_q;
	assign m_axis_tlast = idx_q == AIW'(ANCHORS - 1);

endmodule
